@@ rtl/wsd_pkg.sv @@
// Shared types and codes for the websocket frame deframer.
// Used by wsd_parser, wsd_out_stage and websocket_frame_deframer_top.

package wsd_pkg;

   // Parser phases
   typedef enum logic [2:0] {
      PH_HEAD = 3'd0,
      PH_LEN  = 3'd1,
      PH_EXT  = 3'd2,
      PH_KEY  = 3'd3,
      PH_DATA = 3'd4,
      PH_ERR  = 3'd5
   } phase_type;

   // Result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // Message types
   localparam logic [2:0] MSG_NONE   = 3'd0;
   localparam logic [2:0] MSG_TEXT   = 3'd1;
   localparam logic [2:0] MSG_BINARY = 3'd2;
   localparam logic [2:0] MSG_CLOSE  = 3'd3;
   localparam logic [2:0] MSG_PING   = 3'd4;
   localparam logic [2:0] MSG_PONG   = 3'd5;

   // Frame opcodes
   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   // 7-bit length codes that announce an extended length
   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   typedef struct packed {
      logic       valid;
      logic [1:0] result_kind;
      logic [7:0] payload_byte;
      logic [2:0] message_type;
      logic       frame_final;
      logic       last_of_frame;
      logic       message_done;
   } result_type;

endpackage

@@ rtl/wsd_parser.sv @@
// Frame parser state and the per-byte step logic of the deframer.
// Depends on wsd_pkg for phases, codes and the result struct.

module wsd_parser #(
   parameter int LEN_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           rx_byte,
   output wsd_pkg::result_type  result
);

   wsd_pkg::phase_type  phase_ff, phase_in;
   logic [2:0]          ext_cnt_ff, ext_cnt_in;
   logic [LEN_BITS-1:0] remaining_ff, remaining_in;
   logic [31:0]         mask_key_ff, mask_key_in;
   logic [1:0]          mask_index_ff, mask_index_in;
   logic                masked_ff, masked_in;
   logic                fin_ff, fin_in;
   logic [2:0]          cur_type_ff, cur_type_in;

   logic                head_bad;
   logic [2:0]          head_type;
   logic [LEN_BITS-1:0] len7_ext;
   logic [LEN_BITS-1:0] rem_shift;
   logic [31:0]         key_shift;
   logic [7:0]          key_byte;
   logic                data_last;
   wsd_pkg::result_type empty_res;
   wsd_pkg::result_type error_res;

   always_comb begin
      head_bad  = 1'b0;
      head_type = cur_type_ff;
      case (rx_byte[3:0])
         wsd_pkg::OP_CONT:   head_type = cur_type_ff;
         wsd_pkg::OP_TEXT:   head_type = wsd_pkg::MSG_TEXT;
         wsd_pkg::OP_BINARY: head_type = wsd_pkg::MSG_BINARY;
         wsd_pkg::OP_CLOSE:  head_type = wsd_pkg::MSG_CLOSE;
         wsd_pkg::OP_PING:   head_type = wsd_pkg::MSG_PING;
         wsd_pkg::OP_PONG:   head_type = wsd_pkg::MSG_PONG;
         default:            head_bad  = 1'b1;
      endcase
   end

   always_comb begin
      case (mask_index_ff)
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
   end

   assign len7_ext  = LEN_BITS'(rx_byte[6:0]);
   assign rem_shift = {remaining_ff[LEN_BITS-9:0], rx_byte};
   assign key_shift = {mask_key_ff[23:0], rx_byte};
   assign data_last = (remaining_ff == LEN_BITS'(1));

   always_comb begin
      empty_res               = '0;
      empty_res.valid         = 1'b1;
      empty_res.result_kind   = wsd_pkg::KIND_EMPTY;
      empty_res.message_type  = cur_type_ff;
      empty_res.frame_final   = fin_ff;
      empty_res.last_of_frame = 1'b1;
      empty_res.message_done  = fin_ff;
      error_res               = '0;
      error_res.valid         = 1'b1;
      error_res.result_kind   = wsd_pkg::KIND_ERROR;
   end

   always_comb begin
      phase_in      = phase_ff;
      ext_cnt_in    = ext_cnt_ff;
      remaining_in  = remaining_ff;
      mask_key_in   = mask_key_ff;
      mask_index_in = mask_index_ff;
      masked_in     = masked_ff;
      fin_in        = fin_ff;
      cur_type_in   = cur_type_ff;
      result        = '0;
      if (step) begin
         case (phase_ff)
            wsd_pkg::PH_HEAD: begin
               if (head_bad) begin
                  phase_in = wsd_pkg::PH_ERR;
                  result   = error_res;
               end else begin
                  cur_type_in = head_type;
                  fin_in      = rx_byte[7];
                  phase_in    = wsd_pkg::PH_LEN;
               end
            end
            wsd_pkg::PH_LEN: begin
               masked_in    = rx_byte[7];
               remaining_in = '0;
               if (rx_byte[6:0] == wsd_pkg::LEN7_EXT16) begin
                  ext_cnt_in = 3'd1;
                  phase_in   = wsd_pkg::PH_EXT;
               end else if (rx_byte[6:0] == wsd_pkg::LEN7_EXT64) begin
                  ext_cnt_in = 3'd7;
                  phase_in   = wsd_pkg::PH_EXT;
               end else begin
                  remaining_in = len7_ext;
                  mask_key_in  = '0;
                  if (rx_byte[7]) begin
                     ext_cnt_in = 3'd3;
                     phase_in   = wsd_pkg::PH_KEY;
                  end else begin
                     mask_index_in = '0;
                     if (rx_byte[6:0] == 7'd0) begin
                        result   = empty_res;
                        phase_in = wsd_pkg::PH_HEAD;
                        if (fin_ff) cur_type_in = wsd_pkg::MSG_NONE;
                     end else begin
                        phase_in = wsd_pkg::PH_DATA;
                     end
                  end
               end
            end
            wsd_pkg::PH_EXT: begin
               if (remaining_ff[LEN_BITS-1 -: 8] != 8'd0) begin
                  phase_in = wsd_pkg::PH_ERR;
                  result   = error_res;
               end else begin
                  remaining_in = rem_shift;
                  if (ext_cnt_ff == 3'd0) begin
                     mask_key_in = '0;
                     if (masked_ff) begin
                        ext_cnt_in = 3'd3;
                        phase_in   = wsd_pkg::PH_KEY;
                     end else begin
                        mask_index_in = '0;
                        if (rem_shift == '0) begin
                           result   = empty_res;
                           phase_in = wsd_pkg::PH_HEAD;
                           if (fin_ff) cur_type_in = wsd_pkg::MSG_NONE;
                        end else begin
                           phase_in = wsd_pkg::PH_DATA;
                        end
                     end
                  end else begin
                     ext_cnt_in = ext_cnt_ff - 3'd1;
                  end
               end
            end
            wsd_pkg::PH_KEY: begin
               mask_key_in = key_shift;
               if (ext_cnt_ff == 3'd0) begin
                  mask_index_in = '0;
                  if (remaining_ff == '0) begin
                     result   = empty_res;
                     phase_in = wsd_pkg::PH_HEAD;
                     if (fin_ff) cur_type_in = wsd_pkg::MSG_NONE;
                  end else begin
                     phase_in = wsd_pkg::PH_DATA;
                  end
               end else begin
                  ext_cnt_in = ext_cnt_ff - 3'd1;
               end
            end
            wsd_pkg::PH_DATA: begin
               mask_index_in        = mask_index_ff + 2'd1;
               remaining_in         = remaining_ff - LEN_BITS'(1);
               result.valid         = 1'b1;
               result.result_kind   = wsd_pkg::KIND_PAYLOAD;
               result.payload_byte  = masked_ff ? (rx_byte ^ key_byte) : rx_byte;
               result.message_type  = cur_type_ff;
               result.frame_final   = fin_ff;
               result.last_of_frame = data_last;
               result.message_done  = data_last & fin_ff;
               if (data_last) begin
                  phase_in = wsd_pkg::PH_HEAD;
                  if (fin_ff) cur_type_in = wsd_pkg::MSG_NONE;
               end
            end
            default: begin
               // error phase and unused codes: drop the byte
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= wsd_pkg::PH_HEAD;
         ext_cnt_ff    <= '0;
         remaining_ff  <= '0;
         mask_key_ff   <= '0;
         mask_index_ff <= '0;
         masked_ff     <= 1'b0;
         fin_ff        <= 1'b0;
         cur_type_ff   <= wsd_pkg::MSG_NONE;
      end else begin
         phase_ff      <= phase_in;
         ext_cnt_ff    <= ext_cnt_in;
         remaining_ff  <= remaining_in;
         mask_key_ff   <= mask_key_in;
         mask_index_ff <= mask_index_in;
         masked_ff     <= masked_in;
         fin_ff        <= fin_in;
         cur_type_ff   <= cur_type_in;
      end
   end

   a_error_sticks: assert property (@(posedge clock) disable iff (reset)
      phase_ff == wsd_pkg::PH_ERR |=> phase_ff == wsd_pkg::PH_ERR)
      else $error("parser left the error phase");

   a_error_enters: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.result_kind == wsd_pkg::KIND_ERROR
      |=> phase_ff == wsd_pkg::PH_ERR)
      else $error("error result without entering the error phase");

   a_done_is_final: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.message_done |-> result.last_of_frame && result.frame_final)
      else $error("message done outside a final frame end");

   a_data_nonempty: assert property (@(posedge clock) disable iff (reset)
      phase_ff == wsd_pkg::PH_DATA |-> remaining_ff != '0)
      else $error("payload phase with no bytes left");

endmodule

@@ rtl/wsd_out_stage.sv @@
// Result register of the deframer: holds one result until the response side takes it.
// Depends on wsd_pkg for the result struct.

module wsd_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  wsd_pkg::result_type result,
   input  logic                rsp_stall,
   output logic                advance,
   output logic                rsp_valid,
   output logic [1:0]          rsp_result_kind,
   output logic [7:0]          rsp_payload_byte,
   output logic [2:0]          rsp_message_type,
   output logic                rsp_frame_final,
   output logic                rsp_last_of_frame,
   output logic                rsp_message_done
);

   logic                valid_ff, valid_in;
   wsd_pkg::result_type data_ff, data_in;

   // register is free when empty or being taken this cycle
   assign advance = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = result.valid;
         data_in  = result;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_result_kind   = data_ff.result_kind;
   assign rsp_payload_byte  = data_ff.payload_byte;
   assign rsp_message_type  = data_ff.message_type;
   assign rsp_frame_final   = data_ff.frame_final;
   assign rsp_last_of_frame = data_ff.last_of_frame;
   assign rsp_message_done  = data_ff.message_done;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_stall |-> !load)
      else $error("pending result overwritten");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_stall |=> valid_ff && $stable(data_ff))
      else $error("stalled result changed");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> data_ff.result_kind != 2'd3)
      else $error("undefined result kind");

endmodule

@@ rtl/websocket_frame_deframer_top.sv @@
// Top level of the websocket frame deframer: request register, parser, result register.
// Depends on wsd_pkg, wsd_parser and wsd_out_stage.
//
//   channel   ports                                   direction
//   request   req_valid, req_stall, req_rx_byte       in (stall out)
//   response  rsp_valid, rsp_stall, rsp_result_kind,  out (stall in)
//             rsp_payload_byte, rsp_message_type,
//             rsp_frame_final, rsp_last_of_frame, rsp_message_done
//
// One byte per cycle sustained while rsp_stall is low; a request goes through the request
// register, then the result register, to the response; the parser step is combinational.
// Reset is synchronous and clears all parser state; no clearing pass.
// rsp_stall holds the result register, and the parser step and req_stall follow it
// once the request register is also occupied.

module websocket_frame_deframer_top #(
   parameter int LEN_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_payload_byte,
   output logic [2:0] rsp_message_type,
   output logic       rsp_frame_final,
   output logic       rsp_last_of_frame,
   output logic       rsp_message_done
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff, in_byte_in;
   logic                advance;
   logic                step;
   logic                req_take;
   wsd_pkg::result_type result;

   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   wsd_parser #(
      .LEN_BITS (LEN_BITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   wsd_out_stage u_out (
      .clock             (clock),
      .reset             (reset),
      .load              (step),
      .result            (result),
      .rsp_stall         (rsp_stall),
      .advance           (advance),
      .rsp_valid         (rsp_valid),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_message_type  (rsp_message_type),
      .rsp_frame_final   (rsp_frame_final),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_message_done  (rsp_message_done)
   );

   a_take_when_free: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held request lost or changed");

   a_step_has_request: assert property (@(posedge clock) disable iff (reset)
      step |-> in_valid_ff && advance)
      else $error("parser stepped without a request");

   a_free_accepts: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("empty request register stalled");

endmodule

@@ bench/wsd_frame_checker.sv @@
`timescale 1ns / 1ps
// Watches both channels of websocket_frame_deframer_top, re-parses every accepted
// request byte and compares each response field by field. Depends on wsd_pkg.

module wsd_frame_checker #(
   parameter int LEN_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [1:0] rsp_result_kind,
   input  logic [7:0] rsp_payload_byte,
   input  logic [2:0] rsp_message_type,
   input  logic       rsp_frame_final,
   input  logic       rsp_last_of_frame,
   input  logic       rsp_message_done,
   output int         bad_results,
   output int         results_owed
);

   wsd_pkg::result_type pending_results[$];
   wsd_pkg::phase_type  phase;
   logic [2:0]          hdr_left;
   logic [LEN_BITS-1:0] len_left;
   logic [31:0]         mask_key;
   logic [1:0]          mask_pos;
   logic                masked;
   logic                fin;
   logic [2:0]          msg_type;
   int                  fail_total = 0;

   task automatic owe(input logic [1:0] kind, input logic [7:0] data,
                      input logic [2:0] mtype, input logic f, input logic last,
                      input logic done);
      wsd_pkg::result_type r;
      r.valid = 1'b1;
      r.result_kind = kind;
      r.payload_byte = data;
      r.message_type = mtype;
      r.frame_final = f;
      r.last_of_frame = last;
      r.message_done = done;
      pending_results.push_back(r);
   endtask

   task automatic fail_stream();
      phase = wsd_pkg::PH_ERR;
      owe(wsd_pkg::KIND_ERROR, 8'h00, wsd_pkg::MSG_NONE, 1'b0, 1'b0, 1'b0);
   endtask

   // Header complete: a zero length closes the frame at once.
   task automatic open_payload();
      mask_pos = '0;
      if (len_left == '0) begin
         owe(wsd_pkg::KIND_EMPTY, 8'h00, msg_type, fin, 1'b1, fin);
         if (fin) msg_type = wsd_pkg::MSG_NONE;
         phase = wsd_pkg::PH_HEAD;
      end else begin
         phase = wsd_pkg::PH_DATA;
      end
   endtask

   task automatic close_length();
      mask_key = '0;
      if (masked) begin
         hdr_left = 3'd3;
         phase = wsd_pkg::PH_KEY;
      end else begin
         open_payload();
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      logic [2:0] t;
      logic       reserved;
      logic [7:0] k;
      logic       last;
      t = msg_type;
      reserved = 1'b0;
      k = 8'h00;
      last = 1'b0;
      case (phase)
         wsd_pkg::PH_HEAD: begin
            case (b[3:0])
               wsd_pkg::OP_CONT:   t = msg_type;
               wsd_pkg::OP_TEXT:   t = wsd_pkg::MSG_TEXT;
               wsd_pkg::OP_BINARY: t = wsd_pkg::MSG_BINARY;
               wsd_pkg::OP_CLOSE:  t = wsd_pkg::MSG_CLOSE;
               wsd_pkg::OP_PING:   t = wsd_pkg::MSG_PING;
               wsd_pkg::OP_PONG:   t = wsd_pkg::MSG_PONG;
               default:            reserved = 1'b1;
            endcase
            if (reserved) begin
               fail_stream();
            end else begin
               msg_type = t;
               fin = b[7];
               phase = wsd_pkg::PH_LEN;
            end
         end
         wsd_pkg::PH_LEN: begin
            masked = b[7];
            len_left = '0;
            if (b[6:0] == wsd_pkg::LEN7_EXT16) begin
               hdr_left = 3'd1;
               phase = wsd_pkg::PH_EXT;
            end else if (b[6:0] == wsd_pkg::LEN7_EXT64) begin
               hdr_left = 3'd7;
               phase = wsd_pkg::PH_EXT;
            end else begin
               len_left = LEN_BITS'(b[6:0]);
               close_length();
            end
         end
         wsd_pkg::PH_EXT: begin
            // refuse a byte that would push the length past the counter
            if ((len_left >> (LEN_BITS - 8)) != '0) begin
               fail_stream();
            end else begin
               len_left = {len_left[LEN_BITS-9:0], b};
               if (hdr_left == 3'd0) close_length();
               else hdr_left = hdr_left - 3'd1;
            end
         end
         wsd_pkg::PH_KEY: begin
            mask_key = {mask_key[23:0], b};
            if (hdr_left == 3'd0) open_payload();
            else hdr_left = hdr_left - 3'd1;
         end
         wsd_pkg::PH_DATA: begin
            if (masked) k = mask_key[8 * (3 - int'(mask_pos)) +: 8];
            mask_pos = mask_pos + 2'd1;
            len_left = len_left - LEN_BITS'(1);
            last = (len_left == '0);
            owe(wsd_pkg::KIND_PAYLOAD, b ^ k, msg_type, fin, last, last & fin);
            if (last) begin
               if (fin) msg_type = wsd_pkg::MSG_NONE;
               phase = wsd_pkg::PH_HEAD;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      wsd_pkg::result_type want;
      if (reset) begin
         pending_results.delete();
         phase = wsd_pkg::PH_HEAD;
         hdr_left = '0;
         len_left = '0;
         mask_key = '0;
         mask_pos = '0;
         masked = 1'b0;
         fin = 1'b0;
         msg_type = wsd_pkg::MSG_NONE;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("%0t: unexpected response: kind %0d byte %02h type %0d", $realtime,
                           rsp_result_kind, rsp_payload_byte, rsp_message_type);
            end else begin
               want = pending_results.pop_front();
               if (want.result_kind !== rsp_result_kind ||
                   want.payload_byte !== rsp_payload_byte ||
                   want.message_type !== rsp_message_type ||
                   want.frame_final !== rsp_frame_final ||
                   want.last_of_frame !== rsp_last_of_frame ||
                   want.message_done !== rsp_message_done) begin
                  fail_total++;
                  if (fail_total <= 10)
                     $display({"%0t: response mismatch: want kind %0d byte %02h type %0d",
                               " fin %b last %b done %b / got kind %0d byte %02h type %0d",
                               " fin %b last %b done %b"}, $realtime,
                              want.result_kind, want.payload_byte, want.message_type,
                              want.frame_final, want.last_of_frame, want.message_done,
                              rsp_result_kind, rsp_payload_byte, rsp_message_type,
                              rsp_frame_final, rsp_last_of_frame, rsp_message_done);
               end
            end
         end
         if (req_valid && !req_stall) deframe_byte(req_rx_byte);
      end
      bad_results <= fail_total;
      results_owed <= pending_results.size();
   end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for websocket_frame_deframer_top: feeds framed byte streams under
// changing idle and stall patterns. Depends on wsd_pkg and wsd_frame_checker.

module tb;

   localparam int LEN_BITS     = 32;
   localparam int RANDOM_BYTES = 1500;
   localparam int CYCLE_LIMIT  = 400000;

   // how the frame length is carried
   localparam int FORM_SHORT = 0;
   localparam int FORM_EXT16 = 1;
   localparam int FORM_EXT64 = 2;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_result_kind;
   logic [7:0] rsp_payload_byte;
   logic [2:0] rsp_message_type;
   logic       rsp_frame_final;
   logic       rsp_last_of_frame;
   logic       rsp_message_done;

   int idle_pct = 0;
   int stall_pct = 0;
   int cycles = 0;
   int bytes_sent = 0;
   int bad_results;
   int results_owed;

   always #4 clock = ~clock;

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[websocket_frame_deframer_top] ERROR");
         $finish;
      end
   end

   websocket_frame_deframer_top #(.LEN_BITS(LEN_BITS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_message_type(rsp_message_type),
      .rsp_frame_final(rsp_frame_final),
      .rsp_last_of_frame(rsp_last_of_frame),
      .rsp_message_done(rsp_message_done)
   );

   wsd_frame_checker #(.LEN_BITS(LEN_BITS)) watch (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_message_type(rsp_message_type),
      .rsp_frame_final(rsp_frame_final),
      .rsp_last_of_frame(rsp_last_of_frame),
      .rsp_message_done(rsp_message_done),
      .bad_results(bad_results),
      .results_owed(results_owed)
   );

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [7:0] head, input logic masked, input int len,
                             input int form);
      logic [31:0] mkey;
      mkey = $urandom();
      send_byte(head);
      case (form)
         FORM_EXT16: begin
            send_byte({masked, wsd_pkg::LEN7_EXT16});
            send_byte(8'(len >> 8));
            send_byte(8'(len));
         end
         FORM_EXT64: begin
            send_byte({masked, wsd_pkg::LEN7_EXT64});
            repeat (4) send_byte(8'h00);
            for (int i = 3; i >= 0; i--) send_byte(8'(len >> (8 * i)));
         end
         default: send_byte({masked, 7'(len)});
      endcase
      if (masked)
         for (int i = 3; i >= 0; i--) send_byte(mkey[8 * i +: 8]);
      repeat (len) send_byte(8'($urandom_range(255)));
   endtask

   task automatic random_frame();
      logic [3:0] op;
      int         r;
      int         len;
      int         form;
      case ($urandom_range(5))
         0:       op = wsd_pkg::OP_CONT;
         1:       op = wsd_pkg::OP_TEXT;
         2:       op = wsd_pkg::OP_BINARY;
         3:       op = wsd_pkg::OP_CLOSE;
         4:       op = wsd_pkg::OP_PING;
         default: op = wsd_pkg::OP_PONG;
      endcase
      r = $urandom_range(99);
      form = FORM_SHORT;
      if (r < 10) begin
         len = 0;
      end else if (r < 70) begin
         len = $urandom_range(20, 1);
      end else if (r < 85) begin
         len = $urandom_range(125, 21);
      end else if (r < 95) begin
         form = FORM_EXT16;
         len = $urandom_range(300);
      end else begin
         form = FORM_EXT64;
         len = $urandom_range(40);
      end
      // RSV bits are random noise
      send_frame({1'($urandom_range(1)), 3'($urandom_range(7)), op},
                 1'($urandom_range(1)), len, form);
   endtask

   // Hold the sender until every owed response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
   endtask

   initial begin
      int         base;
      logic [3:0] op;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // open a text message, then a masked empty ping inside it that clears the type
      send_frame({1'b0, 3'b000, wsd_pkg::OP_TEXT}, 1'b0, 1, FORM_SHORT);
      send_frame({1'b1, 3'b111, wsd_pkg::OP_PING}, 1'b1, 0, FORM_SHORT);
      // mask index wraps within a frame and restarts in the next
      send_frame({1'b0, 3'b000, wsd_pkg::OP_BINARY}, 1'b1, 5, FORM_SHORT);
      send_frame({1'b1, 3'b000, wsd_pkg::OP_CONT}, 1'b0, 0, FORM_EXT16);
      send_frame({1'b1, 3'b101, wsd_pkg::OP_PONG}, 1'b0, 1, FORM_EXT64);
      send_frame({1'b1, 3'b000, wsd_pkg::OP_CLOSE}, 1'b1, 125, FORM_SHORT);
      drain();

      base = bytes_sent;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 62; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 62; end
            default: begin idle_pct = 35; stall_pct = 35; end
         endcase
         while (bytes_sent < base + (ph + 1) * RANDOM_BYTES / 4) random_frame();
         drain();
      end

      // end the stream in error: the block stays silent afterwards
      if ($urandom_range(1)) begin
         do op = 4'($urandom_range(15));
         while (op inside {wsd_pkg::OP_CONT, wsd_pkg::OP_TEXT, wsd_pkg::OP_BINARY,
                           wsd_pkg::OP_CLOSE, wsd_pkg::OP_PING, wsd_pkg::OP_PONG});
         send_byte({1'($urandom_range(1)), 3'($urandom_range(7)), op});
      end else begin
         // first extended byte nonzero: the fifth overflows the counter
         send_byte({1'b1, 3'b000, wsd_pkg::OP_BINARY});
         send_byte({1'($urandom_range(1)), wsd_pkg::LEN7_EXT64});
         send_byte(8'($urandom_range(255, 1)));
         repeat (4) send_byte(8'($urandom_range(255)));
      end
      repeat (8) send_byte(8'($urandom_range(255)));
      drain();
      repeat (10) @(posedge clock);

      if (bad_results == 0 && results_owed == 0)
         $display("[websocket_frame_deframer_top] OK");
      else
         $display("[websocket_frame_deframer_top] ERROR");
      $finish;
   end

endmodule
